>>> src/ftw_pkg.sv
// ---------------------------------------------------------------------------
// ftw_pkg
// Shared types and constants of the force/torque window filter with trip.
// ---------------------------------------------------------------------------
`default_nettype none

package ftw_pkg;

	localparam int AXES         = 6;
	localparam int SAMPLE_BITS  = 32;
	localparam int SUM_BITS     = 40;
	localparam int CNT_BITS     = 8;
	localparam int LIMIT_BITS   = 31;
	localparam int NEED_BITS    = 14;
	localparam int WLEN_BITS    = 7;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = 31;
	localparam int SQ_BITS      = 64;

	localparam logic [NEED_BITS-1:0] VIOL_MAX = {NEED_BITS{1'b1}};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef sample_t [AXES-1:0] axes_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FORCE_LIMIT  = 3'd0,
		CFG_TORQUE_LIMIT = 3'd1,
		CFG_FORCE_ON     = 3'd2,
		CFG_TORQUE_ON    = 3'd3,
		CFG_VIOL_NEEDED  = 3'd4,
		CFG_WINDOW_LEN   = 3'd5,
		CFG_FILTER_MODE  = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_AVG,
		L_MEAN,
		L_MDIV,
		L_MED,
		L_DONE
	} lane_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_LANES,
		T_MERGE,
		T_OUT
	} top_state_t;

	typedef struct packed {
		logic start;
		logic filter;
		logic median;
	} lane_cmd_t;

	function automatic logic [SAMPLE_BITS-1:0] abs_sample(input sample_t v);
		return v[SAMPLE_BITS-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

endpackage

`default_nettype wire

>>> src/ftw_intf.sv
// ---------------------------------------------------------------------------
// ftw_intf
// Valid/ready channels for the sample items and the result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface ftw_in_if;
	logic                valid;
	logic                ready;
	ftw_pkg::sample_t    force_x;
	ftw_pkg::sample_t    force_y;
	ftw_pkg::sample_t    force_z;
	ftw_pkg::sample_t    torque_x;
	ftw_pkg::sample_t    torque_y;
	ftw_pkg::sample_t    torque_z;
	logic [ftw_pkg::CNT_BITS-1:0] count_for_average;

	modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
		count_for_average, input ready);
	modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
		count_for_average, output ready);
endinterface

interface ftw_out_if;
	logic                valid;
	logic                ready;
	ftw_pkg::sample_t    filt_force_x;
	ftw_pkg::sample_t    filt_force_y;
	ftw_pkg::sample_t    filt_force_z;
	ftw_pkg::sample_t    filt_torque_x;
	ftw_pkg::sample_t    filt_torque_y;
	ftw_pkg::sample_t    filt_torque_z;
	logic                filtered_ok;
	logic                trip;

	modport source (output valid, filt_force_x, filt_force_y, filt_force_z, filt_torque_x,
		filt_torque_y, filt_torque_z, filtered_ok, trip, input ready);
	modport sink (input valid, filt_force_x, filt_force_y, filt_force_z, filt_torque_x,
		filt_torque_y, filt_torque_z, filtered_ok, trip, output ready);
endinterface

`default_nettype wire

>>> src/ftw_div.sv
// ---------------------------------------------------------------------------
// ftw_div
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module ftw_div #(
	parameter int DW = 40,
	parameter int VW = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] num,
	input  wire logic [VW-1:0]        den,
	output logic                      done,
	output logic signed [DW-1:0]      quo
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] den_q;
	logic          neg_q;

	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
				quo_q  <= num[DW-1] ? $unsigned(-num) : $unsigned(num);
				rem_q  <= '0;
				neg_q  <= num[DW-1];
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

>>> src/ftw_lane.sv
// ---------------------------------------------------------------------------
// ftw_lane
// One axis: step sum, step average, sample window and mean/median filter.
// ---------------------------------------------------------------------------
`default_nettype none

module ftw_lane #(
	parameter int WINDOW_MAX = 64,
	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int LW = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          add,
	input  wire ftw_pkg::sample_t              sample,
	input  wire ftw_pkg::lane_cmd_t            cmd,
	input  wire logic [ftw_pkg::CNT_BITS-1:0]  cnt,
	input  wire logic [LW-1:0]                 len,
	input  wire logic [IW-1:0]                 slot,
	output logic                               done,
	output ftw_pkg::sample_t                   value
);

	localparam int SB    = ftw_pkg::SAMPLE_BITS;
	localparam int ACC_W = SB + LW;
	localparam int DW    = (ACC_W > ftw_pkg::SUM_BITS) ? ACC_W : ftw_pkg::SUM_BITS;
	localparam int VW    = (LW > ftw_pkg::CNT_BITS) ? LW : ftw_pkg::CNT_BITS;
	localparam logic signed [DW-1:0] SAT_HI = {{(DW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

	ftw_pkg::lane_state_t state_q, state_d;

	logic [ftw_pkg::SUM_BITS-1:0] sum_q;
	ftw_pkg::sample_t             mem [WINDOW_MAX];
	ftw_pkg::sample_t             rd_q;
	ftw_pkg::sample_t             cand_q;
	ftw_pkg::sample_t             value_q;
	logic [IW-1:0]                scan_addr_q;
	logic [IW-1:0]                cand_addr_q;
	logic [LW-1:0]                scan_j_q;
	logic [LW-1:0]                cand_k_q;
	logic [LW-1:0]                rank_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic                         rd_v_s1;
	logic [LW-1:0]                rd_j_s1;

	logic                         div_start;
	logic signed [DW-1:0]         div_num;
	logic [VW-1:0]                div_den;
	logic                         div_done;
	logic signed [DW-1:0]         div_quo;
	ftw_pkg::sample_t             sat;
	logic                         issue;
	logic                         scan_end;
	logic                         match;
	logic                         less;
	logic                         wr_en;

	function automatic logic [IW-1:0] dec_slot(input logic [IW-1:0] a);
		return (a == '0) ? IW'(WINDOW_MAX - 1) : a - 1'b1;
	endfunction

	ftw_div #(.DW(DW), .VW(VW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		if (div_quo > SAT_HI)
			sat = {1'b0, {(SB-1){1'b1}}};
		else if (div_quo < SAT_LO)
			sat = {1'b1, {(SB-1){1'b0}}};
		else
			sat = div_quo[SB-1:0];
		less  = (rd_q < cand_q) || ((rd_q == cand_q) && (rd_j_s1 < cand_k_q));
		scan_end = (scan_j_q == len) && !rd_v_s1;
		match = rank_q == (len >> 1);
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = DW'($signed(sum_q));
		div_den   = VW'(cnt);
		wr_en     = 1'b0;
		issue     = 1'b0;
		case (state_q)
			ftw_pkg::L_IDLE: begin
				if (cmd.start) begin
					div_start = 1'b1;
					state_d   = ftw_pkg::L_AVG;
				end
			end
			ftw_pkg::L_AVG: begin
				if (div_done) begin
					wr_en = 1'b1;
					if (!cmd.filter)
						state_d = ftw_pkg::L_DONE;
					else if (cmd.median)
						state_d = ftw_pkg::L_MED;
					else
						state_d = ftw_pkg::L_MEAN;
				end
			end
			ftw_pkg::L_MEAN: begin
				issue = scan_j_q != len;
				if (scan_end) begin
					div_start = 1'b1;
					div_num   = DW'(acc_q);
					div_den   = VW'(len);
					state_d   = ftw_pkg::L_MDIV;
				end
			end
			ftw_pkg::L_MDIV: begin
				if (div_done)
					state_d = ftw_pkg::L_DONE;
			end
			ftw_pkg::L_MED: begin
				issue = scan_j_q != len;
				if (scan_end && match)
					state_d = ftw_pkg::L_DONE;
			end
			ftw_pkg::L_DONE: begin
				// held until the next step so that lanes finishing apart line up
				if (cmd.start) begin
					div_start = 1'b1;
					state_d   = ftw_pkg::L_AVG;
				end
			end
			default: begin
				state_d = ftw_pkg::L_IDLE;
			end
		endcase
	end

	// window memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[slot] <= sat;
		rd_q   <= mem[scan_addr_q];
		cand_q <= mem[cand_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftw_pkg::L_IDLE;
			sum_q       <= '0;
			scan_addr_q <= '0;
			cand_addr_q <= '0;
			scan_j_q    <= '0;
			cand_k_q    <= '0;
			rank_q      <= '0;
			rd_v_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (add)
				sum_q <= sum_q + ftw_pkg::SUM_BITS'(sample);
			if (wr_en) begin
				sum_q       <= '0;
				scan_addr_q <= slot;
				cand_addr_q <= slot;
				scan_j_q    <= '0;
				cand_k_q    <= '0;
				rank_q      <= '0;
			end
			if (issue) begin
				scan_addr_q <= dec_slot(scan_addr_q);
				scan_j_q    <= scan_j_q + 1'b1;
			end
			if (rd_v_s1 && state_q == ftw_pkg::L_MED)
				rank_q <= rank_q + LW'(less);
			if (state_q == ftw_pkg::L_MED && scan_end && !match) begin
				cand_k_q    <= cand_k_q + 1'b1;
				cand_addr_q <= dec_slot(cand_addr_q);
				scan_addr_q <= slot;
				scan_j_q    <= '0;
				rank_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_j_s1 <= scan_j_q;
		if (wr_en)
			acc_q <= '0;
		else if (rd_v_s1 && state_q == ftw_pkg::L_MEAN)
			acc_q <= acc_q + ACC_W'(rd_q);
		if (state_q == ftw_pkg::L_MDIV && div_done)
			value_q <= sat;
		else if (state_q == ftw_pkg::L_MED && scan_end && match)
			value_q <= cand_q;
	end

	assign done  = state_q == ftw_pkg::L_DONE;
	assign value = value_q;

endmodule

`default_nettype wire

>>> src/ftw_merge.sv
// ---------------------------------------------------------------------------
// ftw_merge
// Squared force/torque magnitudes, threshold test and violation counter.
// ---------------------------------------------------------------------------
`default_nettype none

module ftw_merge (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire ftw_pkg::axes_t                  vals,
	input  wire logic [ftw_pkg::LIMIT_BITS-1:0]  force_limit,
	input  wire logic [ftw_pkg::LIMIT_BITS-1:0]  torque_limit,
	input  wire logic                            force_on,
	input  wire logic                            torque_on,
	input  wire logic [ftw_pkg::NEED_BITS-1:0]   need,
	output logic                                 done,
	output logic                                 trip
);

	localparam int QW = ftw_pkg::SQ_BITS;
	localparam int NB = ftw_pkg::NEED_BITS;

	logic [QW-1:0] sq_s1 [ftw_pkg::AXES];
	logic [QW-1:0] flim_s1, tlim_s1;
	logic [QW-1:0] fsum_s2, tsum_s2, flim_s2, tlim_s2;
	logic          v_s1, v_s2;
	logic [NB-1:0] count_q;
	logic          done_q, trip_q;

	logic          viol;
	logic [NB-1:0] need_eff;
	logic [NB-1:0] count_inc;

	always_ff @(posedge clk) begin
		for (int a = 0; a < ftw_pkg::AXES; a++)
			sq_s1[a] <= QW'(ftw_pkg::abs_sample(vals[a])) * QW'(ftw_pkg::abs_sample(vals[a]));
		flim_s1 <= QW'(force_limit) * QW'(force_limit);
		tlim_s1 <= QW'(torque_limit) * QW'(torque_limit);
		fsum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		tsum_s2 <= sq_s1[3] + sq_s1[4] + sq_s1[5];
		flim_s2 <= flim_s1;
		tlim_s2 <= tlim_s1;
	end

	always_comb begin
		viol = (force_on && fsum_s2 >= flim_s2) || (torque_on && tsum_s2 >= tlim_s2);
		need_eff = (need == '0) ? NB'(1) : need;
		if (!viol)
			count_inc = '0;
		else if (count_q != ftw_pkg::VIOL_MAX)
			count_inc = count_q + 1'b1;
		else
			count_inc = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_q  <= 1'b0;
			trip_q  <= 1'b0;
			count_q <= '0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
			if (v_s2) begin
				if (count_inc >= need_eff) begin
					trip_q  <= 1'b1;
					count_q <= '0;
				end else begin
					trip_q  <= 1'b0;
					count_q <= count_inc;
				end
			end
		end
	end

	assign done = done_q;
	assign trip = trip_q;

endmodule

`default_nettype wire

>>> src/force_torque_window_filter_trip.sv
// an item with a zero count is taken and gives no result
// a closing item is averaged by the divider, then filtered by a mean (window sum, then a division)
//   or a median (ranking scan per candidate), then, with a full window, tested against the limits and registered
// one item at a time; the averaging divider, the window scan and output back-pressure set the rate
// reset clears control state, sums, counters and the violation count;
//   the window memory is not cleared and needs no clearing pass
// ---------------------------------------------------------------------------
// force_torque_window_filter_trip
// Six-lane force/torque window filter with magnitude threshold trip.
// ---------------------------------------------------------------------------
`default_nettype none

module force_torque_window_filter_trip #(
	parameter int WINDOW_MAX    = 64,
	parameter int AVG_COUNT_MAX = 255
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	ftw_in_if.sink                                 sample_in,
	ftw_out_if.source                              result_out,
	input  wire logic                              cfg_we,
	input  wire logic [ftw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [ftw_pkg::CFG_BITS-1:0]      cfg_data
);

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int CB = ftw_pkg::CNT_BITS;

	ftw_pkg::top_state_t state_q, state_d;

	logic [ftw_pkg::LIMIT_BITS-1:0] force_limit_q, torque_limit_q;
	logic                           force_on_q, torque_on_q, mode_q;
	logic [ftw_pkg::NEED_BITS-1:0]  need_q;
	logic [ftw_pkg::WLEN_BITS-1:0]  wlen_q;

	logic [IW-1:0] oldest_q, slot_q;
	logic [LW-1:0] fill_q, len_q, len_now, fill_next;
	logic [CB-1:0] cnt_q, cnt_now;
	logic          filt_q, start_q;

	logic          accept;
	ftw_pkg::axes_t in_vals, lane_vals;
	logic [ftw_pkg::AXES-1:0] lane_done;
	ftw_pkg::lane_cmd_t cmd;
	logic          merge_start, merge_done, merge_trip;
	logic          load_out;

	logic           out_valid_q, ok_q, trip_q;
	ftw_pkg::axes_t out_vals_q;

	assign accept = sample_in.valid && sample_in.ready;
	assign sample_in.ready = state_q == ftw_pkg::T_IDLE;

	assign in_vals[0] = sample_in.force_x;
	assign in_vals[1] = sample_in.force_y;
	assign in_vals[2] = sample_in.force_z;
	assign in_vals[3] = sample_in.torque_x;
	assign in_vals[4] = sample_in.torque_y;
	assign in_vals[5] = sample_in.torque_z;

	always_comb begin
		if (wlen_q == '0)
			len_now = LW'(1);
		else if (int'(wlen_q) > WINDOW_MAX)
			len_now = LW'(WINDOW_MAX);
		else
			len_now = LW'(wlen_q);
		fill_next = (fill_q == LW'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1;
		if (int'(sample_in.count_for_average) > AVG_COUNT_MAX)
			cnt_now = CB'(AVG_COUNT_MAX);
		else
			cnt_now = sample_in.count_for_average;
	end

	assign cmd.start  = start_q;
	assign cmd.filter = filt_q;
	assign cmd.median = mode_q;

	for (genvar a = 0; a < ftw_pkg::AXES; a++) begin : g_lane
		ftw_lane #(.WINDOW_MAX(WINDOW_MAX)) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.add   (accept),
			.sample(in_vals[a]),
			.cmd   (cmd),
			.cnt   (cnt_q),
			.len   (len_q),
			.slot  (slot_q),
			.done  (lane_done[a]),
			.value (lane_vals[a])
		);
	end

	ftw_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (merge_start),
		.vals        (lane_vals),
		.force_limit (force_limit_q),
		.torque_limit(torque_limit_q),
		.force_on    (force_on_q),
		.torque_on   (torque_on_q),
		.need        (need_q),
		.done        (merge_done),
		.trip        (merge_trip)
	);

	always_comb begin
		state_d     = state_q;
		merge_start = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ftw_pkg::T_IDLE: begin
				if (accept && sample_in.count_for_average != '0)
					state_d = ftw_pkg::T_LANES;
			end
			ftw_pkg::T_LANES: begin
				if (&lane_done && !start_q) begin
					if (filt_q) begin
						merge_start = 1'b1;
						state_d     = ftw_pkg::T_MERGE;
					end else begin
						state_d = ftw_pkg::T_OUT;
					end
				end
			end
			ftw_pkg::T_MERGE: begin
				if (merge_done)
					state_d = ftw_pkg::T_OUT;
			end
			ftw_pkg::T_OUT: begin
				if (!out_valid_q || result_out.ready) begin
					load_out = 1'b1;
					state_d  = ftw_pkg::T_IDLE;
				end
			end
			default: begin
				state_d = ftw_pkg::T_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ftw_pkg::T_IDLE;
			force_limit_q  <= ftw_pkg::LIMIT_BITS'(6553600);
			torque_limit_q <= ftw_pkg::LIMIT_BITS'(655360);
			force_on_q     <= 1'b0;
			torque_on_q    <= 1'b0;
			need_q         <= ftw_pkg::NEED_BITS'(10);
			wlen_q         <= ftw_pkg::WLEN_BITS'(1);
			mode_q         <= 1'b0;
			oldest_q       <= '0;
			fill_q         <= '0;
			start_q        <= 1'b0;
			filt_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= 1'b0;
			if (cfg_we) begin
				case (ftw_pkg::cfg_idx_t'(cfg_index))
					ftw_pkg::CFG_FORCE_LIMIT:  force_limit_q  <= cfg_data;
					ftw_pkg::CFG_TORQUE_LIMIT: torque_limit_q <= cfg_data;
					ftw_pkg::CFG_FORCE_ON:     force_on_q     <= cfg_data[0];
					ftw_pkg::CFG_TORQUE_ON:    torque_on_q    <= cfg_data[0];
					ftw_pkg::CFG_VIOL_NEEDED:  need_q <= cfg_data[ftw_pkg::NEED_BITS-1:0];
					ftw_pkg::CFG_WINDOW_LEN:   wlen_q <= cfg_data[ftw_pkg::WLEN_BITS-1:0];
					ftw_pkg::CFG_FILTER_MODE:  mode_q         <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && sample_in.count_for_average != '0) begin
				start_q  <= 1'b1;
				filt_q   <= fill_next >= len_now;
				fill_q   <= fill_next;
				oldest_q <= (oldest_q == IW'(WINDOW_MAX - 1)) ? '0 : oldest_q + 1'b1;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (result_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	// step context held for the lanes
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= oldest_q;
			len_q  <= len_now;
			cnt_q  <= cnt_now;
		end
		if (load_out) begin
			out_vals_q <= filt_q ? lane_vals : '0;
			ok_q       <= filt_q;
			trip_q     <= filt_q && merge_trip;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.filt_force_x  = out_vals_q[0];
	assign result_out.filt_force_y  = out_vals_q[1];
	assign result_out.filt_force_z  = out_vals_q[2];
	assign result_out.filt_torque_x = out_vals_q[3];
	assign result_out.filt_torque_y = out_vals_q[4];
	assign result_out.filt_torque_z = out_vals_q[5];
	assign result_out.filtered_ok   = ok_q;
	assign result_out.trip          = trip_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the force/torque window filter with trip against an in-bench
// predictor: directed rows, some with hand-typed results, then phased random
// traffic over several register settings, mostly with random idling on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam ftw_pkg::sample_t SMAX = 32'sh7fff_ffff;
	localparam ftw_pkg::sample_t SMIN = 32'sh8000_0000;
	localparam int WMAX = 64;
	localparam int CMAX = 255;

	typedef struct packed {
		ftw_pkg::axes_t ax;
		logic [7:0]     cnt;
	} ft_item_t;

	typedef struct packed {
		ftw_pkg::axes_t filt;
		logic  ok;
		logic  trip;
	} ft_result_t;

	typedef struct packed {
		ft_item_t   item;
		logic       typed;
		ft_result_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ftw_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [ftw_pkg::CFG_BITS-1:0] cfg_data;

	ftw_in_if  in_ch ();
	ftw_out_if out_ch ();

	force_torque_window_filter_trip u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(in_ch),
		.result_out(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [30:0] m_force_lim, m_torque_lim;
	logic m_force_on, m_torque_on, m_median;
	logic [13:0] m_need;
	logic [6:0] m_wlen;
	longint win_vals [ftw_pkg::AXES][WMAX];
	int unsigned win_fill, next_slot, viol_run;
	logic signed [39:0] step_sum [ftw_pkg::AXES];

	ft_result_t filt_q [$];
	int errs, n_items, n_results, n_trips, n_ok;
	bit snd_idle_en, rdy_idle_en;
	int rdy_gap;
	dir_row_t dir_rows [$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic ftw_pkg::sample_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: begin
				return ftw_pkg::sample_t'($urandom);
			end
			1: begin
				case ($urandom_range(0, 3))
					0: return SMAX;
					1: return SMIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				return ftw_pkg::sample_t'($signed($urandom_range(0, 32'h0040_0000)) -
					32'sh0020_0000);
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 8'd0;
		if (r < 90) return 8'($urandom_range(1, 4));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic ft_item_t rand_item();
		ft_item_t it;
		for (int i = 0; i < ftw_pkg::AXES; i++) it.ax[i] = rand_sample();
		it.cnt = rand_count();
		return it;
	endfunction

	function automatic logic [63:0] mag_sq(input longint a, input longint b, input longint c);
		logic [63:0] ua, ub, uc;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		uc = c < 0 ? -c : c;
		return ua * ua + ub * ub + uc * uc;
	endfunction

	// advance the predictor by one item; returns 1 when a result is due
	function automatic bit filter_step(input ft_item_t it, output ft_result_t res);
		longint v, acc;
		longint buf_v [WMAX];
		longint filt [ftw_pkg::AXES];
		int unsigned cnt, len, need, slot, j;
		bit viol;
		res = '0;
		for (int i = 0; i < ftw_pkg::AXES; i++)
			step_sum[i] = step_sum[i] + {{8{it.ax[i][31]}}, it.ax[i]};
		cnt = it.cnt;
		if (cnt == 0) return 0;
		if (cnt > CMAX) cnt = CMAX;
		slot = next_slot;
		for (int i = 0; i < ftw_pkg::AXES; i++) begin
			v = longint'(step_sum[i]) / longint'(cnt);
			if (v > longint'(SMAX)) v = SMAX;
			if (v < longint'(SMIN)) v = SMIN;
			win_vals[i][slot] = v;
			step_sum[i] = '0;
		end
		next_slot = (slot + 1) % WMAX;
		if (win_fill < WMAX) win_fill++;
		len = m_wlen == 0 ? 1 : (m_wlen > WMAX ? WMAX : m_wlen);
		res.ok = win_fill >= len;
		if (!res.ok) return 1;
		for (int i = 0; i < ftw_pkg::AXES; i++) begin
			acc = 0;
			for (int k = 0; k < len; k++) begin
				v = win_vals[i][(next_slot + WMAX - 1 - k) % WMAX];
				acc += v;
				j = k;
				while (j > 0 && buf_v[j-1] > v) begin
					buf_v[j] = buf_v[j-1];
					j--;
				end
				buf_v[j] = v;
			end
			filt[i] = m_median ? buf_v[len/2] : acc / longint'(len);
			res.filt[i] = ftw_pkg::sample_t'(filt[i]);
		end
		viol = 0;
		if (m_force_on && mag_sq(filt[0], filt[1], filt[2]) >=
				{33'd0, m_force_lim} * {33'd0, m_force_lim})
			viol = 1;
		if (m_torque_on && mag_sq(filt[3], filt[4], filt[5]) >=
				{33'd0, m_torque_lim} * {33'd0, m_torque_lim})
			viol = 1;
		if (viol) begin
			if (viol_run < ftw_pkg::VIOL_MAX) viol_run++;
		end else begin
			viol_run = 0;
		end
		need = m_need == 0 ? 1 : m_need;
		if (viol_run >= need) begin
			res.trip = 1'b1;
			viol_run = 0;
		end
		return 1;
	endfunction

	task automatic send_item(input ft_item_t it, input bit typed, input ft_result_t typed_res);
		ft_result_t res;
		int gap;
		if (snd_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		{in_ch.torque_z, in_ch.torque_y, in_ch.torque_x,
			in_ch.force_z, in_ch.force_y, in_ch.force_x} = it.ax;
		in_ch.count_for_average = it.cnt;
		do @(posedge clk); while (!in_ch.ready);
		n_items++;
		if (filter_step(it, res))
			filt_q.insert(filt_q.size(), typed ? typed_res : res);
	endtask

	task automatic add_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (filt_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input ftw_pkg::cfg_idx_t idx, input logic [30:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			ftw_pkg::CFG_FORCE_LIMIT:  m_force_lim = val;
			ftw_pkg::CFG_TORQUE_LIMIT: m_torque_lim = val;
			ftw_pkg::CFG_FORCE_ON:     m_force_on = val[0];
			ftw_pkg::CFG_TORQUE_ON:    m_torque_on = val[0];
			ftw_pkg::CFG_VIOL_NEEDED:  m_need = val[13:0];
			ftw_pkg::CFG_WINDOW_LEN:   m_wlen = val[6:0];
			default:                   m_median = val[0];
		endcase
	endtask

	task automatic set_phase(input logic [30:0] fl, input logic [30:0] tl, input bit fon,
			input bit ton, input int need, input int wlen, input bit med);
		settle();
		write_reg(ftw_pkg::CFG_FORCE_LIMIT, fl);
		write_reg(ftw_pkg::CFG_TORQUE_LIMIT, tl);
		write_reg(ftw_pkg::CFG_FORCE_ON, 31'(fon));
		write_reg(ftw_pkg::CFG_TORQUE_ON, 31'(ton));
		write_reg(ftw_pkg::CFG_VIOL_NEEDED, 31'(need));
		write_reg(ftw_pkg::CFG_WINDOW_LEN, 31'(wlen));
		write_reg(ftw_pkg::CFG_FILTER_MODE, 31'(med));
	endtask

	task automatic run_random(input int n);
		for (int k = 0; k < n; k++) send_item(rand_item(), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		if (rdy_gap != 0) begin
			out_ch.ready <= 1'b0;
			rdy_gap <= rdy_gap - 1;
		end else if (rdy_idle_en && $urandom_range(0, 7) == 0) begin
			out_ch.ready <= 1'b0;
			rdy_gap <= $urandom_range(0, 12);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		ft_result_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.filt = {out_ch.filt_torque_z, out_ch.filt_torque_y, out_ch.filt_torque_x,
				out_ch.filt_force_z, out_ch.filt_force_y, out_ch.filt_force_x};
			got.ok = out_ch.filtered_ok;
			got.trip = out_ch.trip;
			if (filt_q.size() == 0) begin
				errs++;
				$display("%0t: expected no result item actual %h", $time, got);
			end else begin
				want = filt_q.pop_front();
				n_results++;
				n_trips += got.trip;
				n_ok += got.ok;
				for (int i = 0; i < ftw_pkg::AXES; i++)
					if (got.filt[i] !== want.filt[i]) begin
						errs++;
						$display("%0t: axis %0d expected %0d actual %0d", $time, i,
							want.filt[i], got.filt[i]);
					end
				if (got.ok !== want.ok) begin
					errs++;
					$display("%0t: filtered_ok expected %b actual %b", $time, want.ok, got.ok);
				end
				if (got.trip !== want.trip) begin
					errs++;
					$display("%0t: trip expected %b actual %b", $time, want.trip, got.trip);
				end
			end
		end
	end

	initial begin
		ft_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		{in_ch.torque_z, in_ch.torque_y, in_ch.torque_x,
			in_ch.force_z, in_ch.force_y, in_ch.force_x} = '0;
		in_ch.count_for_average = '0;
		out_ch.ready = 1'b0;
		rdy_gap = 0;
		errs = 0;
		n_items = 0;
		n_results = 0;
		n_trips = 0;
		n_ok = 0;
		m_force_lim = 31'd6553600;
		m_torque_lim = 31'd655360;
		m_force_on = 0;
		m_torque_on = 0;
		m_need = 14'd10;
		m_wlen = 7'd1;
		m_median = 0;
		win_fill = 0;
		next_slot = 0;
		viol_run = 0;
		for (int i = 0; i < ftw_pkg::AXES; i++) step_sum[i] = '0;
		snd_idle_en = 1;
		rdy_idle_en = 1;

		// reset window of one, mean filter, tests off
		add_row('{'{{6{32'sd0}}, 8'd1}, 1'b1, '{{6{32'sd0}}, 1'b1, 1'b0}});
		add_row('{'{{6{SMAX}}, 8'd1}, 1'b1, '{{6{SMAX}}, 1'b1, 1'b0}});
		add_row('{'{{6{SMIN}}, 8'd1}, 1'b1, '{{6{SMIN}}, 1'b1, 1'b0}});
		add_row('{'{{6{SMAX}}, 8'd0}, 1'b0, '0});
		add_row('{'{{6{SMAX}}, 8'd2}, 1'b1, '{{6{SMAX}}, 1'b1, 1'b0}});
		add_row('{'{{6{SMIN}}, 8'd0}, 1'b0, '0});
		add_row('{'{{6{SMIN}}, 8'd0}, 1'b0, '0});
		add_row('{'{{6{SMIN}}, 8'd3}, 1'b1, '{{6{SMIN}}, 1'b1, 1'b0}});
		// averaged value saturates
		add_row('{'{{6{SMAX}}, 8'd0}, 1'b0, '0});
		add_row('{'{{6{SMAX}}, 8'd1}, 1'b1, '{{6{SMAX}}, 1'b1, 1'b0}});
		add_row('{'{{6{SMIN}}, 8'd0}, 1'b0, '0});
		add_row('{'{{6{SMIN}}, 8'd1}, 1'b1, '{{6{SMIN}}, 1'b1, 1'b0}});
		// truncation toward zero and the largest divisor
		add_row('{'{{32'sd3, -32'sd3, 32'sd1, -32'sd1, SMAX, SMIN}, 8'd0}, 1'b0, '0});
		add_row('{'{{-32'sd2, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 8'd2}, 1'b0, '0});
		add_row('{'{{6{32'sh1234_5678}}, 8'd255}, 1'b0, '0});
		add_row('{'{{SMIN, SMAX, -32'sd7, 32'sd7, -32'sd1, 32'sd1}, 8'd255}, 1'b0, '0});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);

		// largest window with mean: not full at first
		set_phase(31'd6553600, 31'd655360, 1, 1, 3, 64, 0);
		run_random(150);
		// median over five, every violation trips
		set_phase(31'd6553600, 31'd655360, 1, 1, 1, 5, 1);
		run_random(100);
		settle();
		run_random(100);
		// zero window acts as one, zero force limit, 10000 violations needed
		set_phase(31'd0, 31'h7fff_ffff, 1, 0, 10000, 0, 1);
		run_random(100);
		// zero violations needed acts as one, torque only
		set_phase(31'h7fff_ffff, 31'd0, 0, 1, 0, 2, 0);
		run_random(150);
		// oversized window acts as the maximum, median
		set_phase(31'd3000000, 31'd900000, 1, 1, 2, 127, 1);
		run_random(40);
		// step sums wrap at 40 bits
		set_phase(31'd6553600, 31'd655360, 1, 1, 4, 3, 0);
		for (int k = 0; k < 300; k++) begin
			for (int i = 0; i < ftw_pkg::AXES; i++)
				it.ax[i] = (i % 2) ? SMIN : SMAX - ftw_pkg::sample_t'($urandom_range(0, 255));
			it.cnt = 8'd0;
			send_item(it, 1'b0, '0);
		end
		it.cnt = 8'd1;
		send_item(it, 1'b0, '0);
		run_random(20);

		for (int p = 0; p < 4; p++) begin
			set_phase(31'($urandom_range(0, 32'h0080_0000)), 31'($urandom_range(0, 32'h0080_0000)),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 6),
				$urandom_range(1, 12), $urandom_range(0, 1));
			if (p == 3) begin
				snd_idle_en = 0;
				rdy_idle_en = 0;
			end
			run_random(110);
		end

		settle();
		repeat (5000) @(posedge clk);
		if (filt_q.size() != 0) begin
			errs++;
			$display("%0t: %0d result items never arrived", $time, filt_q.size());
		end
		$display("%0d items sent over 11 register settings, %0d results checked", n_items,
			n_results);
		$display("%0d with a full window, %0d trips, %0d mismatches", n_ok, n_trips, errs);
		if (errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
